@@ rtl/core/dqpi_pkg.sv @@
// dqpi_pkg: shared widths, constants, types and helpers for the dq current PI core.
// Used by dqpi_mul, dqpi_div, dqpi_sqrt and dq_current_pi_with_feedforward_core.
package dqpi_pkg;

  // Field widths
  localparam int VW      = 32;   // currents and voltages, signed Q16.16
  localparam int FRAC    = 16;
  localparam int VDC_W   = 31;
  localparam int INTEG_W = 48;
  localparam int LIM_W   = 47;

  // Serial multiplier: magnitude A times magnitude B, one bit of B per cycle
  localparam int MUL_AW  = 48;
  localparam int MUL_BW  = 32;
  localparam int PROD_W  = MUL_AW + MUL_BW;
  localparam int RES_W   = 64;

  // Serial divider and square root
  localparam int DIVN_W  = VDC_W + FRAC;   // headroom << FRAC
  localparam int DIVD_W  = 32;
  localparam int SQ_W    = 62;
  localparam int ROOT_W  = SQ_W / 2;

  localparam logic [31:0] RPM_TO_RAD = 32'd449767923;   // pi/30, Q0.32
  localparam logic [31:0] INV_SQRT3  = 32'd2479700525;  // 1/sqrt3, Q0.32
  localparam logic [LIM_W-1:0] INTEG_MAX = {LIM_W{1'b1}};

  // Post-multiply shift codes
  localparam logic [1:0] SH0  = 2'd0;
  localparam logic [1:0] SH16 = 2'd1;
  localparam logic [1:0] SH32 = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_KPQ  = 3'd0;
  localparam logic [2:0] REG_KIQ  = 3'd1;
  localparam logic [2:0] REG_KPD  = 3'd2;
  localparam logic [2:0] REG_KID  = 3'd3;
  localparam logic [2:0] REG_IND  = 3'd4;
  localparam logic [2:0] REG_FLUX = 3'd5;
  localparam logic [2:0] REG_PP   = 3'd6;
  localparam logic [2:0] REG_MODE = 3'd7;

  typedef struct packed {
    logic       start;
    logic       a_neg;
    logic       b_neg;
    logic [1:0] sh;
  } mul_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [63:0] clamp_sym(input logic signed [63:0] v,
                                                   input logic [LIM_W-1:0] lim);
    logic signed [63:0] l;
    l = $signed({17'b0, lim});
    if (v > l) return l;
    else if (v < -l) return -l;
    else return v;
  endfunction

  function automatic logic [MUL_AW-1:0] mag48(input logic signed [63:0] v);
    logic [63:0] t;
    t = (v < 0) ? 64'(-v) : 64'(v);
    return t[MUL_AW-1:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return (v < 0) ? 32'(-v) : 32'(v);
  endfunction

endpackage

@@ rtl/core/dqpi_mul.sv @@
// dqpi_mul: bit-serial shift-add multiplier with signed floor shift of the product.
// Depends on dqpi_pkg.
module dqpi_mul
  import dqpi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  mul_req_t                 req,
  input  logic [MUL_AW-1:0]        a,
  input  logic [MUL_BW-1:0]        b,
  output logic                     done,
  output logic signed [RES_W-1:0]  res
);

  localparam int CW = $clog2(MUL_BW);

  logic [MUL_AW-1:0] hi_r, a_r;
  logic [MUL_BW-1:0] lo_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r, neg_r;
  logic [1:0]        sh_r;
  logic [MUL_AW:0]   sum;
  logic [PROD_W-1:0] prod;
  logic [62:0]       q;
  logic              stk;
  logic [RES_W-1:0]  m;

  // add A when the current multiplier bit is set
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  // step one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        hi_r   <= '0;
        lo_r   <= b;
        a_r    <= a;
        neg_r  <= req.a_neg ^ req.b_neg;
        sh_r   <= req.sh;
      end else if (busy_r) begin
        hi_r  <= sum[MUL_AW:1];
        lo_r  <= {sum[0], lo_r[MUL_BW-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(MUL_BW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift down with floor rounding for negative results
  assign prod = {hi_r, lo_r};
  always_comb begin
    case (sh_r)
      SH16: begin
        q   = prod[78:16];
        stk = |prod[15:0];
      end
      SH32: begin
        q   = {15'b0, prod[79:32]};
        stk = |prod[31:0];
      end
      default: begin
        q   = prod[62:0];
        stk = 1'b0;
      end
    endcase
    m = {1'b0, q} + RES_W'(stk & neg_r);
  end

  assign res  = neg_r ? -$signed(m) : $signed(m);
  assign done = done_r;

endmodule

@@ rtl/core/dqpi_div.sv @@
// dqpi_div: restoring divider, one quotient bit per cycle.
// Depends on dqpi_pkg.
module dqpi_div
  import dqpi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVN_W-1:0] dividend,
  input  logic [DIVD_W-1:0] divisor,
  output logic              done,
  output logic [DIVN_W-1:0] quotient
);

  localparam int CW = $clog2(DIVN_W);

  logic [DIVD_W-1:0] rem_r, d_r;
  logic [DIVN_W-1:0] quo_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;
  logic [DIVD_W+1:0] diff;

  // trial subtract of the divisor from the shifted remainder
  assign diff = {1'b0, rem_r, quo_r[DIVN_W-1]} - {2'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        d_r    <= divisor;
      end else if (busy_r) begin
        if (!diff[DIVD_W+1]) begin
          rem_r <= diff[DIVD_W-1:0];
          quo_r <= {quo_r[DIVN_W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[DIVD_W-2:0], quo_r[DIVN_W-1]};
          quo_r <= {quo_r[DIVN_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIVN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/core/dqpi_sqrt.sv @@
// dqpi_sqrt: digit-by-digit integer square root, one root bit per cycle.
// Depends on dqpi_pkg.
module dqpi_sqrt
  import dqpi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CW = $clog2(ROOT_W);

  logic [SQ_W-1:0]   rad_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;
  logic [ROOT_W+4:0] r2, trial, diff;

  // bring down two bits, try root*4+1
  assign r2    = {1'b0, rem_r, rad_r[SQ_W-1:SQ_W-2]};
  assign trial = {3'b0, root_r, 2'b01};
  assign diff  = r2 - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r <= {rad_r[SQ_W-3:0], 2'b00};
        if (!diff[ROOT_W+4]) begin
          rem_r  <= diff[ROOT_W+1:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= r2[ROOT_W+1:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ rtl/core/dq_current_pi_with_feedforward_core.sv @@
// dq_current_pi_with_feedforward_core: one FOC current-loop tick per input word.
// Depends on dqpi_pkg, dqpi_mul, dqpi_div and dqpi_sqrt.
//
// One word in gives one d/q voltage word out. A sequencer drives a single
// bit-serial multiplier, a bit-serial divider for the two integrator limits and
// a bit-serial square root for the q-axis circle limit. Most of a tick is spent
// in the multiplier. One word is processed at a time; the next word is taken
// while the previous result still waits at the output register. Configuration
// must be written only while idle; the core itself does not enforce this.
module dq_current_pi_with_feedforward_core
  import dqpi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // rotor_speed[15:0], q_meas[47:16], d_meas[79:48], q_target[111:80],
  // d_target[143:112], bus_voltage[174:144], zero pad[175]
  input  logic [175:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // d_voltage[31:0], q_voltage[63:32]
  output logic [63:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_FF0  = 5'd1;
  localparam logic [4:0] ST_FF1  = 5'd2;
  localparam logic [4:0] ST_FF2  = 5'd3;
  localparam logic [4:0] ST_FF3  = 5'd4;
  localparam logic [4:0] ST_FF4  = 5'd5;
  localparam logic [4:0] ST_FF5  = 5'd6;
  localparam logic [4:0] ST_HEAD = 5'd7;
  localparam logic [4:0] ST_DIVQ = 5'd8;
  localparam logic [4:0] ST_DIVD = 5'd9;
  localparam logic [4:0] ST_INTG = 5'd10;
  localparam logic [4:0] ST_PQ   = 5'd11;
  localparam logic [4:0] ST_IQ   = 5'd12;
  localparam logic [4:0] ST_PD   = 5'd13;
  localparam logic [4:0] ST_ID   = 5'd14;
  localparam logic [4:0] ST_VLIM = 5'd15;
  localparam logic [4:0] ST_CLMP = 5'd16;
  localparam logic [4:0] ST_SQL  = 5'd17;
  localparam logic [4:0] ST_SQE  = 5'd18;
  localparam logic [4:0] ST_SQRT = 5'd19;
  localparam logic [4:0] ST_OUT  = 5'd20;

  // Configuration
  logic [31:0] kpq_r, kiq_r, kpd_r, kid_r, ind_r, flux_r;
  logic [6:0]  pp_r;
  logic [1:0]  mode_r;

  // Sequencer and data path
  logic [4:0]                state_r;
  logic                      issued_r;
  logic signed [15:0]        rpm_r;
  logic signed [31:0]        iqm_r, idm_r, iqt_r, idt_r;
  logic [VDC_W-1:0]          vdc_r, head_r, vlim_r;
  logic signed [31:0]        w_r, react_r, vdff_r, vqff_r, errq_r, errd_r;
  logic signed [63:0]        tmp_r, eq_r, ed_r;
  logic [LIM_W-1:0]          limq_r, limd_r;
  logic signed [INTEG_W-1:0] qint_r, dint_r;
  logic [SQ_W-1:0]           sqa_r, rad_r;
  logic                      out_valid_r;
  logic [31:0]               out_d_r, out_q_r;

  mul_req_t                  mreq;
  logic [MUL_AW-1:0]         mul_a;
  logic [MUL_BW-1:0]         mul_b;
  logic                      mul_done;
  logic signed [RES_W-1:0]   mul_res;
  logic                      div_start, div_done;
  logic [DIVN_W-1:0]         div_q;
  logic [31:0]               div_den;
  logic                      sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]         sqrt_root;
  logic [31:0]               aq;
  logic signed [63:0]        sum_q, sum_d;
  logic                      out_free;

  dqpi_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .res  (mul_res)
  );

  dqpi_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend({head_r, {FRAC{1'b0}}}),
    .divisor (div_den),
    .done    (div_done),
    .quotient(div_q)
  );

  dqpi_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sqrt_start),
    .radicand(rad_r),
    .done    (sqrt_done),
    .root    (sqrt_root)
  );

  // Select multiplier operands for the current step
  always_comb begin
    mreq       = '0;
    mul_a      = '0;
    mul_b      = '0;
    mreq.start = 1'b0;
    case (state_r)
      ST_FF0: begin
        mul_a = mag48(64'(rpm_r)); mreq.a_neg = rpm_r < 0;
        mul_b = {25'b0, pp_r}; mreq.sh = SH0; mreq.start = !issued_r;
      end
      ST_FF1: begin
        mul_a = mag48(tmp_r); mreq.a_neg = tmp_r < 0;
        mul_b = RPM_TO_RAD; mreq.sh = SH16; mreq.start = !issued_r;
      end
      ST_FF2: begin
        mul_a = mag48(64'(w_r)); mreq.a_neg = w_r < 0;
        mul_b = ind_r; mreq.sh = SH32; mreq.start = !issued_r;
      end
      ST_FF3: begin
        mul_a = mag48(64'(react_r)); mreq.a_neg = react_r < 0;
        mul_b = mag32(iqm_r); mreq.b_neg = iqm_r < 0;
        mreq.sh = SH16; mreq.start = !issued_r;
      end
      ST_FF4: begin
        mul_a = mag48(64'(react_r)); mreq.a_neg = react_r < 0;
        mul_b = mag32(idm_r); mreq.b_neg = idm_r < 0;
        mreq.sh = SH16; mreq.start = !issued_r;
      end
      ST_FF5: begin
        mul_a = mag48(64'(w_r)); mreq.a_neg = w_r < 0;
        mul_b = flux_r; mreq.sh = SH32; mreq.start = !issued_r;
      end
      ST_PQ: begin
        mul_a = mag48(64'(errq_r)); mreq.a_neg = errq_r < 0;
        mul_b = kpq_r; mreq.sh = SH16; mreq.start = !issued_r;
      end
      ST_IQ: begin
        mul_a = mag48(64'(qint_r)); mreq.a_neg = qint_r < 0;
        mul_b = kiq_r; mreq.sh = SH16; mreq.start = !issued_r;
      end
      ST_PD: begin
        mul_a = mag48(64'(errd_r)); mreq.a_neg = errd_r < 0;
        mul_b = kpd_r; mreq.sh = SH16; mreq.start = !issued_r;
      end
      ST_ID: begin
        mul_a = mag48(64'(dint_r)); mreq.a_neg = dint_r < 0;
        mul_b = kid_r; mreq.sh = SH16; mreq.start = !issued_r;
      end
      ST_VLIM: begin
        mul_a = {17'b0, vdc_r}; mul_b = INV_SQRT3; mreq.sh = SH32;
        mreq.start = !issued_r && mode_r[1];
      end
      ST_SQL: begin
        mul_a = {17'b0, vlim_r}; mul_b = {1'b0, vlim_r}; mreq.sh = SH0;
        mreq.start = !issued_r;
      end
      ST_SQE: begin
        mul_a = mag48(ed_r); mul_b = mag32($signed(ed_r[31:0])); mreq.sh = SH0;
        mreq.start = !issued_r;
      end
      default: mreq.start = 1'b0;
    endcase
  end

  assign div_den    = (state_r == ST_DIVQ) ? kiq_r : kid_r;
  assign div_start  = !issued_r && ((state_r == ST_DIVQ && kiq_r != '0) ||
                                    (state_r == ST_DIVD && kid_r != '0));
  assign sqrt_start = !issued_r && (state_r == ST_SQRT);

  assign aq       = mag32(vqff_r);
  assign sum_q    = 64'(qint_r) + 64'(errq_r);
  assign sum_d    = 64'(dint_r) + 64'(errd_r);
  assign out_free = !out_valid_r || out_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kpq_r  <= '0;
      kiq_r  <= '0;
      kpd_r  <= '0;
      kid_r  <= '0;
      ind_r  <= '0;
      flux_r <= '0;
      pp_r   <= 7'd1;
      mode_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KPQ:  kpq_r  <= cfg_data;
        REG_KIQ:  kiq_r  <= cfg_data;
        REG_KPD:  kpd_r  <= cfg_data;
        REG_KID:  kid_r  <= cfg_data;
        REG_IND:  ind_r  <= cfg_data;
        REG_FLUX: flux_r <= cfg_data;
        REG_PP:   pp_r   <= cfg_data[6:0];
        REG_MODE: mode_r <= cfg_data[1:0];
        default:  mode_r <= mode_r;
      endcase
    end
  end

  // Sequencer: advance one step as each unit finishes, or at once for steps that use no unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      qint_r      <= '0;
      dint_r      <= '0;
    end else begin
      if (out_valid_r && out_tready && state_r != ST_OUT) out_valid_r <= 1'b0;
      if (mreq.start || div_start || sqrt_start) issued_r <= 1'b1;
      if (mul_done || div_done || sqrt_done) issued_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            rpm_r  <= $signed(in_tdata[15:0]);
            iqm_r  <= $signed(in_tdata[47:16]);
            idm_r  <= $signed(in_tdata[79:48]);
            iqt_r  <= $signed(in_tdata[111:80]);
            idt_r  <= $signed(in_tdata[143:112]);
            vdc_r  <= in_tdata[174:144];
            w_r    <= '0;
            vdff_r <= '0;
            vqff_r <= '0;
            state_r <= mode_r[0] ? ST_FF0 : ST_HEAD;
          end
        end
        ST_FF0: if (mul_done) begin tmp_r <= mul_res; state_r <= ST_FF1; end
        ST_FF1: if (mul_done) begin w_r <= sat32(mul_res); state_r <= ST_FF2; end
        ST_FF2: if (mul_done) begin react_r <= mul_res[31:0]; state_r <= ST_FF3; end
        ST_FF3: if (mul_done) begin vdff_r <= sat32(-mul_res); state_r <= ST_FF4; end
        ST_FF4: if (mul_done) begin tmp_r <= 64'(sat32(mul_res)); state_r <= ST_FF5; end
        ST_FF5: if (mul_done) begin
          vqff_r  <= sat32(tmp_r + mul_res);
          state_r <= ST_HEAD;
        end
        ST_HEAD: begin
          head_r  <= ({1'b0, vdc_r} > aq) ? VDC_W'({1'b0, vdc_r} - aq) : '0;
          errq_r  <= sat32(64'(iqt_r) - 64'(iqm_r));
          errd_r  <= sat32(64'(idt_r) - 64'(idm_r));
          state_r <= ST_DIVQ;
        end
        ST_DIVQ: begin
          if (kiq_r == '0) begin
            limq_r <= INTEG_MAX; state_r <= ST_DIVD;
          end else if (div_done) begin
            limq_r <= div_q; state_r <= ST_DIVD;
          end
        end
        ST_DIVD: begin
          if (kid_r == '0) begin
            limd_r <= INTEG_MAX; state_r <= ST_INTG;
          end else if (div_done) begin
            limd_r <= div_q; state_r <= ST_INTG;
          end
        end
        ST_INTG: begin
          qint_r  <= INTEG_W'(clamp_sym(sum_q, limq_r));
          dint_r  <= INTEG_W'(clamp_sym(sum_d, limd_r));
          state_r <= ST_PQ;
        end
        ST_PQ: if (mul_done) begin tmp_r <= mul_res; state_r <= ST_IQ; end
        ST_IQ: if (mul_done) begin
          eq_r <= tmp_r + mul_res + 64'(vqff_r); state_r <= ST_PD;
        end
        ST_PD: if (mul_done) begin tmp_r <= mul_res; state_r <= ST_ID; end
        ST_ID: if (mul_done) begin
          ed_r <= tmp_r + mul_res + 64'(vdff_r); state_r <= ST_VLIM;
        end
        ST_VLIM: begin
          if (!mode_r[1]) begin
            vlim_r <= vdc_r; state_r <= ST_CLMP;
          end else if (mul_done) begin
            vlim_r <= mul_res[VDC_W-1:0]; state_r <= ST_CLMP;
          end
        end
        ST_CLMP: begin
          ed_r    <= clamp_sym(ed_r, LIM_W'(vlim_r));
          state_r <= ST_SQL;
        end
        ST_SQL: if (mul_done) begin sqa_r <= mul_res[SQ_W-1:0]; state_r <= ST_SQE; end
        ST_SQE: if (mul_done) begin
          rad_r <= sqa_r - mul_res[SQ_W-1:0]; state_r <= ST_SQRT;
        end
        ST_SQRT: if (sqrt_done) begin
          eq_r    <= clamp_sym(eq_r, LIM_W'(sqrt_root));
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_d_r     <= ed_r[31:0];
            out_q_r     <= eq_r[31:0];
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_q_r, out_d_r};

  // Unit completions only arrive while the sequencer waits on them
  a_mul_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> issued_r)
    else $error("multiplier result with no request outstanding");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIVQ || state_r == ST_DIVD))
    else $error("divider result outside limit steps");

  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_FF0 || state_r == ST_HEAD))
    else $error("accepted word did not start a tick");

  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PQ) |->
      (64'(qint_r) <= $signed({17'b0, limq_r}) && 64'(qint_r) >= -$signed({17'b0, limq_r})))
    else $error("q integrator outside its limit");

endmodule
